// File: hdl/ocil_pkg.sv
// ----------------------------------------------------------------------------
// ocil_pkg
// Shared widths, request and status codes for the ordered column lookup unit.
// ----------------------------------------------------------------------------
package ocil_pkg;

  localparam int unsigned Depth  = 64;
  localparam int unsigned IdxW   = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned ValW   = 32;
  localparam int unsigned MagW   = ValW;
  localparam int unsigned FracW  = 16;
  localparam int unsigned StepW  = $clog2(FracW);
  localparam int unsigned WtW    = FracW + 1;
  localparam int unsigned StW    = 4;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [WtW-1:0] QOne = WtW'(1) << FracW;

  localparam logic [ReqW-1:0] REQ_APPEND     = 3'd0;
  localparam logic [ReqW-1:0] REQ_APPEND_DEF = 3'd1;
  localparam logic [ReqW-1:0] REQ_UPDATE     = 3'd2;
  localparam logic [ReqW-1:0] REQ_READ       = 3'd3;
  localparam logic [ReqW-1:0] REQ_LOOKUP     = 3'd4;

  localparam logic [StW-1:0] ST_OK         = 4'd0;
  localparam logic [StW-1:0] ST_ORDER      = 4'd1;
  localparam logic [StW-1:0] ST_NODEFAULT  = 4'd2;
  localparam logic [StW-1:0] ST_BADINDEX   = 4'd3;
  localparam logic [StW-1:0] ST_DEFAULTED  = 4'd4;
  localparam logic [StW-1:0] ST_UNORDERED  = 4'd5;
  localparam logic [StW-1:0] ST_FEW        = 4'd6;
  localparam logic [StW-1:0] ST_HASDEFAULT = 4'd7;
  localparam logic [StW-1:0] ST_OUTOFRANGE = 4'd8;
  localparam logic [StW-1:0] ST_FULL       = 4'd9;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_INC  = 2'd1;
  localparam logic [1:0] MODE_DEC  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_ORDER_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ORDER_STRICT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEFAULTS_OK  = 2'd2;

endpackage

// File: hdl/ocil_div.sv
// ----------------------------------------------------------------------------
// ocil_div
// Restoring Q1.16 ratio of two magnitudes, one quotient bit per cycle,
// rounded to nearest with halves up, saturated at one.
// ----------------------------------------------------------------------------
module ocil_div import ocil_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [MagW-1:0] num_i,
  input  logic [MagW-1:0] den_i,
  output logic            done_o,
  output logic [WtW-1:0]  quot_o
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_RND} dstate_e;

  dstate_e                 state_q;
  logic [MagW-1:0]         rem_q, den_q;
  logic [FracW-1:0]        q_q;
  logic [StepW-1:0]        cnt_q;
  logic [MagW:0]           twice;
  logic                    ge;

  assign twice = {rem_q, 1'b0};
  assign ge    = twice >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_o  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            den_q <= den_i;
            rem_q <= num_i;
            q_q   <= '0;
            cnt_q <= '0;
            if (num_i == '0) begin
              quot_o <= '0;
              done_o <= 1'b1;
            end else if (num_i >= den_i) begin
              quot_o <= QOne;
              done_o <= 1'b1;
            end else begin
              state_q <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem_q <= ge ? MagW'(twice - {1'b0, den_q}) : MagW'(twice);
          q_q   <= {q_q[FracW-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == StepW'(FracW - 1)) state_q <= D_RND;
        end
        D_RND: begin
          quot_o  <= {1'b0, q_q} + WtW'(ge);
          done_o  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/ordered_column_interp_lookup_unit.sv
// ----------------------------------------------------------------------------
// ordered_column_interp_lookup_unit
// Column store with default marks, order checks and sorted-table lookup
// returning the bracketing interval and a Q1.16 interpolation weight.
// ----------------------------------------------------------------------------
// Requests that fail their dispatch checks are rejected there. A lookup sweeps
// all N entries for min/max, then runs a search of about log2(N) probes:
// min/max sweep and search share one memory read port. The divider runs last
// and finishes early when no division is needed. One request at a time:
// busy stays high until the result strobe. The result cannot be stalled.
// Reset: fill and default counts clear, config returns to increasing/strict
// with defaults off; column memory contents are not cleared.
module ordered_column_interp_lookup_unit import ocil_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ReqW-1:0]     req_type_i,
  input  logic [IdxW-1:0]     entry_index_i,
  input  logic [ValW-1:0]     data_value_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                result_valid_o,
  output logic [StW-1:0]      status_o,
  output logic [ValW-1:0]     read_value_o,
  output logic                is_default_o,
  output logic [IdxW-1:0]     interval_index_o,
  output logic [WtW-1:0]      interp_weight_o,
  output logic [CntW-1:0]     entry_count_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_WAIT, S_SELF, S_NEXT, S_PREV, S_WRITE, S_RDATA,
    S_MM, S_RANGE, S_BS, S_LA, S_LB, S_DIVS, S_DIVW
  } state_e;

  state_e            state_q, ret_q;
  logic [ValW:0]     mem [Depth];
  logic [ValW:0]     rdata_q;
  logic [IdxW-1:0]   addr_q, pos_q, k_q, lo_q, hi_q;
  logic [ReqW-1:0]   req_q;
  logic [ValW-1:0]   x_q, mn_q, mx_q, a_q, wval_q;
  logic              wmark_q, self_def_q;
  logic [CntW-1:0]   fill_q, defcnt_q;
  logic [1:0]        mode_q;
  logic              strict_q, defok_q;
  logic [MagW-1:0]   num_q, den_q;
  logic              div_done;
  logic [WtW-1:0]    div_quot;

  logic [ValW-1:0]   rv;
  logic              rmark, below;
  logic [IdxW-1:0]   nlo, nhi, mid;
  logic [CntW-1:0]   pos_p1;

  function automatic logic lt(input logic [ValW-1:0] a, input logic [ValW-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic pair_ok(input logic [1:0] mode, input logic strict,
                                   input logic [ValW-1:0] first,
                                   input logic [ValW-1:0] second);
    logic r;
    r = 1'b1;
    if (mode == MODE_INC) r = strict ? lt(first, second) : !lt(second, first);
    else if (mode == MODE_DEC) r = strict ? lt(second, first) : !lt(first, second);
    return r;
  endfunction

  assign rv     = rdata_q[ValW-1:0];
  assign rmark  = rdata_q[ValW];
  assign below  = lt(rv, x_q);
  assign nlo    = (below ^ (mode_q == MODE_DEC)) ? addr_q : lo_q;
  assign nhi    = (below ^ (mode_q == MODE_DEC)) ? hi_q : addr_q;
  assign mid    = IdxW'(({1'b0, nlo} + {1'b0, nhi}) >> 1);
  assign pos_p1 = CntW'(pos_q) + 1'b1;

  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign entry_count_o = fill_q;

  always_ff @(posedge clk_i) begin
    if (state_q == S_WRITE) mem[pos_q] <= {wmark_q, wval_q};
    rdata_q <= mem[addr_q];
  end

  ocil_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_DIVS),
    .num_i   (num_q),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      ret_q          <= S_IDLE;
      fill_q         <= '0;
      defcnt_q       <= '0;
      mode_q         <= MODE_INC;
      strict_q       <= 1'b1;
      defok_q        <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_ORDER_MODE:   mode_q   <= cfg_data_i[1:0];
          CFG_ORDER_STRICT: strict_q <= cfg_data_i[0];
          CFG_DEFAULTS_OK:  defok_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        S_IDLE: begin
          if (start) begin
            req_q            <= req_type_i;
            pos_q            <= entry_index_i;
            x_q              <= data_value_i;
            status_o         <= ST_OK;
            read_value_o     <= '0;
            is_default_o     <= 1'b0;
            interval_index_o <= '0;
            interp_weight_o  <= '0;
            state_q          <= S_DISP;
          end
        end
        S_DISP: begin
          state_q    <= S_IDLE;
          self_def_q <= 1'b0;
          wmark_q    <= 1'b0;
          wval_q     <= x_q;
          case (req_q)
            REQ_APPEND: begin
              pos_q <= fill_q[IdxW-1:0];
              if (fill_q >= CntW'(Depth)) begin
                status_o <= ST_FULL; result_valid_o <= 1'b1;
              end else if (fill_q != '0) begin
                addr_q <= IdxW'(fill_q - 1'b1); ret_q <= S_PREV; state_q <= S_WAIT;
              end else begin
                state_q <= S_WRITE;
              end
            end
            REQ_APPEND_DEF: begin
              pos_q   <= fill_q[IdxW-1:0];
              wmark_q <= 1'b1;
              wval_q  <= '0;
              if (!defok_q) begin
                status_o <= ST_NODEFAULT; result_valid_o <= 1'b1;
              end else if (fill_q >= CntW'(Depth)) begin
                status_o <= ST_FULL; result_valid_o <= 1'b1;
              end else begin
                state_q <= S_WRITE;
              end
            end
            REQ_UPDATE, REQ_READ: begin
              if (CntW'(pos_q) >= fill_q) begin
                status_o <= ST_BADINDEX; result_valid_o <= 1'b1;
              end else begin
                addr_q  <= pos_q;
                ret_q   <= (req_q == REQ_READ) ? S_RDATA : S_SELF;
                state_q <= S_WAIT;
              end
            end
            REQ_LOOKUP: begin
              if (mode_q != MODE_INC && mode_q != MODE_DEC) begin
                status_o <= ST_UNORDERED; result_valid_o <= 1'b1;
              end else if (fill_q < CntW'(2)) begin
                status_o <= ST_FEW; result_valid_o <= 1'b1;
              end else if (defcnt_q != '0) begin
                status_o <= ST_HASDEFAULT; result_valid_o <= 1'b1;
              end else begin
                addr_q <= '0; k_q <= '0; ret_q <= S_MM; state_q <= S_WAIT;
              end
            end
            default: result_valid_o <= 1'b1;
          endcase
        end
        S_WAIT: state_q <= ret_q;
        S_SELF: begin
          self_def_q <= rmark;
          state_q    <= S_WAIT;
          if (pos_p1 < fill_q) begin
            addr_q <= IdxW'(pos_p1); ret_q <= S_NEXT;
          end else if (pos_q != '0) begin
            addr_q <= pos_q - 1'b1; ret_q <= S_PREV;
          end else begin
            state_q <= S_WRITE;
          end
        end
        S_NEXT: begin
          if (!rmark && !pair_ok(mode_q, strict_q, x_q, rv)) begin
            status_o <= ST_ORDER; result_valid_o <= 1'b1; state_q <= S_IDLE;
          end else if (pos_q != '0) begin
            addr_q <= pos_q - 1'b1; ret_q <= S_PREV; state_q <= S_WAIT;
          end else begin
            state_q <= S_WRITE;
          end
        end
        S_PREV: begin
          if (!rmark && !pair_ok(mode_q, strict_q, rv, x_q)) begin
            status_o <= ST_ORDER; result_valid_o <= 1'b1; state_q <= S_IDLE;
          end else begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (req_q == REQ_UPDATE) begin
            if (self_def_q) defcnt_q <= defcnt_q - 1'b1;
          end else begin
            fill_q <= fill_q + 1'b1;
            if (wmark_q) defcnt_q <= defcnt_q + 1'b1;
          end
          result_valid_o <= 1'b1;
          state_q        <= S_IDLE;
        end
        S_RDATA: begin
          if (rmark) begin
            status_o <= ST_DEFAULTED; is_default_o <= 1'b1;
          end else begin
            read_value_o <= rv;
          end
          result_valid_o <= 1'b1;
          state_q        <= S_IDLE;
        end
        S_MM: begin
          if (k_q == '0 || lt(rv, mn_q)) mn_q <= rv;
          if (k_q == '0 || lt(mx_q, rv)) mx_q <= rv;
          if (CntW'(k_q) == fill_q - 1'b1) begin
            state_q <= S_RANGE;
          end else begin
            k_q <= k_q + 1'b1; addr_q <= k_q + 1'b1; ret_q <= S_MM; state_q <= S_WAIT;
          end
        end
        S_RANGE: begin
          lo_q <= '0;
          hi_q <= IdxW'(fill_q - 1'b1);
          if (lt(x_q, mn_q) || lt(mx_q, x_q)) begin
            status_o <= ST_OUTOFRANGE; result_valid_o <= 1'b1; state_q <= S_IDLE;
          end else if (fill_q > CntW'(2)) begin
            addr_q <= IdxW'((fill_q - 1'b1) >> 1); ret_q <= S_BS; state_q <= S_WAIT;
          end else begin
            addr_q <= '0; ret_q <= S_LA; state_q <= S_WAIT;
          end
        end
        S_BS: begin
          lo_q    <= nlo;
          hi_q    <= nhi;
          state_q <= S_WAIT;
          if (CntW'(nlo) + 1'b1 < CntW'(nhi)) begin
            addr_q <= mid; ret_q <= S_BS;
          end else begin
            addr_q <= nlo; ret_q <= S_LA;
          end
        end
        S_LA: begin
          a_q    <= rv;
          lo_q   <= addr_q;
          addr_q <= addr_q + 1'b1;
          ret_q  <= S_LB;
          state_q <= S_WAIT;
        end
        S_LB: begin
          interval_index_o <= lo_q;
          if (a_q == rv) begin
            interp_weight_o <= QOne; result_valid_o <= 1'b1; state_q <= S_IDLE;
          end else begin
            if (lt(a_q, rv)) begin
              den_q <= MagW'(rv - a_q);
              num_q <= lt(rv, x_q) ? '0 : MagW'(rv - x_q);
            end else begin
              den_q <= MagW'(a_q - rv);
              num_q <= lt(x_q, rv) ? '0 : MagW'(x_q - rv);
            end
            state_q <= S_DIVS;
          end
        end
        S_DIVS: state_q <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            interp_weight_o <= div_quot; result_valid_o <= 1'b1; state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy)) else $error("result without a request");
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted request not taken up");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (entry_count_o <= CntW'(Depth)) && (defcnt_q <= fill_q))
    else $error("fill or default count out of range");
  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> interp_weight_o <= QOne) else $error("weight above one");

endmodule
